### rtl/energy_meter_frame_decoder_top_assert.svh
// assertion macros for the energy meter frame decoder
`ifndef ENERGY_METER_FRAME_DECODER_TOP_ASSERT_SVH
`define ENERGY_METER_FRAME_DECODER_TOP_ASSERT_SVH

// checked outside reset
`define EMFD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define EMFD_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

### rtl/emfd_pkg.sv
// package of the energy meter frame decoder: types, codes and constants
`timescale 1ns / 1ps
package emfd_pkg;
    localparam int FRAME_LENGTH = 24;
    localparam logic [7:0] SYNC_BYTE = 8'h55;
    localparam logic [7:0] CONFIRM_BYTE = 8'h5A;
    localparam int COEF_W = 20;
    localparam int POS_W = 5;
    localparam int CNT_W = 6;
    localparam int MUL_STEPS = 32;
    localparam int DIV_STEPS = 48;
    localparam int PF_W = 18;
    localparam int TDATA_W = 168;
    localparam logic [COEF_W-1:0] VCOEF_RESET = 20'd197001;
    localparam logic [COEF_W-1:0] ICOEF_RESET = 20'd20316;
    localparam logic [COEF_W-1:0] PCOEF_RESET = 20'd59572;

    typedef enum logic [1:0] {
        REG_VCOEF = 2'd0,
        REG_ICOEF = 2'd1,
        REG_PCOEF = 2'd2,
        REG_NONE  = 2'd3
    } t_reg;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_MUL  = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_FIN  = 4'b1000
    } t_state;

    typedef enum logic [2:0] {
        OP_V  = 3'd0,
        OP_I  = 3'd1,
        OP_P  = 3'd2,
        OP_S  = 3'd3,
        OP_PF = 3'd4
    } t_op;
endpackage

### rtl/energy_meter_frame_decoder_top.sv
// top level of the energy meter frame decoder
`timescale 1ns / 1ps
`include "energy_meter_frame_decoder_top_assert.svh"
// Takes one byte per beat from the metering chip. A 0x55 byte (re)starts a frame, a
// following 0x5A confirms it, and the next 22 bytes complete it. Bytes are taken in
// one cycle each while the decoder is idle. On the last byte of a frame a bit-serial
// shift-add multiplier and a restoring divider (one quotient bit a cycle) are shared
// over the three scaled quotients, apparent power and power factor; a final state
// then loads the result beat, and no byte is taken until the decoder is idle again.
// The load waits for as long as an earlier result beat is still unaccepted. A finished
// result waits in the output register while the next frame is received.
module energy_meter_frame_decoder_top (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [1:0]                   i_cfg_addr,
    input  logic [emfd_pkg::COEF_W-1:0]  i_cfg_wdata,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [7:0]                   s_axis_tdata,  // rx_byte
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // voltage, current, active_power, apparent_power, power_factor, pulse_count, pad
    output logic [emfd_pkg::TDATA_W-1:0] m_axis_tdata
);
    import emfd_pkg::*;

    t_state r_state, n_state;
    t_op r_op, n_op;
    logic [POS_W-1:0] r_pos, n_pos;
    logic [COEF_W-1:0] r_vcoef, r_icoef, r_pcoef;
    logic [143:0] r_frame;
    logic [15:0] r_pulse;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [31:0] r_ma, n_ma, r_mb, n_mb, r_div, n_div, r_rem, n_rem;
    logic [63:0] r_acc, n_acc;
    logic [47:0] r_dq, n_dq;
    logic [31:0] r_v, n_v, r_i, n_i, r_p, n_p, r_s, n_s;
    logic [PF_W-1:0] r_pf, n_pf;
    logic r_m_valid, n_m_valid;
    logic [TDATA_W-1:0] r_m_data, n_m_data;
    logic rx_beat, frame_done;
    logic [32:0] mul_sum, div_trial;
    logic [23:0] sel_param, sel_count;
    logic [COEF_W-1:0] sel_coef;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign rx_beat = s_axis_tvalid && s_axis_tready;
    assign frame_done = rx_beat && (s_axis_tdata != SYNC_BYTE)
                        && !(s_axis_tdata == CONFIRM_BYTE && r_pos == POS_W'(1))
                        && (r_pos == POS_W'(FRAME_LENGTH - 1));
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata = r_m_data;

    assign mul_sum = {1'b0, r_acc[63:32]} + (r_mb[0] ? {1'b0, r_ma} : 33'd0);
    assign div_trial = {r_rem, r_dq[47]} - {1'b0, r_div};

    // operands of the next scaled quotient
    always_comb begin
        unique case (n_op)
            OP_I: begin
                sel_param = r_frame[95:72];
                sel_count = r_frame[71:48];
                sel_coef = r_icoef;
            end
            OP_P: begin
                sel_param = r_frame[47:24];
                sel_count = r_frame[23:0];
                sel_coef = r_pcoef;
            end
            default: begin
                sel_param = r_frame[143:120];
                sel_count = r_frame[119:96];
                sel_coef = r_vcoef;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        n_op = r_op;
        n_pos = r_pos;
        n_cnt = r_cnt;
        n_ma = r_ma;
        n_mb = r_mb;
        n_acc = r_acc;
        n_div = r_div;
        n_rem = r_rem;
        n_dq = r_dq;
        n_v = r_v;
        n_i = r_i;
        n_p = r_p;
        n_s = r_s;
        n_pf = r_pf;
        n_m_valid = r_m_valid && !m_axis_tready;
        n_m_data = r_m_data;
        unique case (r_state)
            ST_IDLE: begin
                if (rx_beat) begin
                    priority if (s_axis_tdata == SYNC_BYTE) begin
                        n_pos = POS_W'(1);
                    end else if (s_axis_tdata == CONFIRM_BYTE && r_pos == POS_W'(1)) begin
                        n_pos = POS_W'(2);
                    end else if (r_pos >= POS_W'(2)) begin
                        n_pos = r_pos + POS_W'(1);
                        if (frame_done) begin
                            n_pos = '0;
                            n_state = ST_MUL;
                            n_op = OP_V;
                        end
                    end else begin
                        n_pos = '0;
                    end
                end
            end
            ST_MUL: begin
                n_acc = {mul_sum, r_acc[31:1]};
                n_mb = {1'b0, r_mb[31:1]};
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(MUL_STEPS - 1)) begin
                    n_cnt = '0;
                    n_state = ST_DIV;
                    n_rem = '0;
                    if (r_op == OP_S) begin
                        n_s = (|n_acc[63:48]) ? 32'hFFFF_FFFF : n_acc[47:16];
                        n_op = OP_PF;
                        n_div = n_s;
                        n_dq = {r_p, 16'd0};
                    end else begin
                        n_dq = n_acc[47:0];
                    end
                end
            end
            ST_DIV: begin
                if (!div_trial[32]) begin
                    n_rem = div_trial[31:0];
                    n_dq = {r_dq[46:0], 1'b1};
                end else begin
                    n_rem = {r_rem[30:0], r_dq[47]};
                    n_dq = {r_dq[46:0], 1'b0};
                end
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    n_cnt = '0;
                    unique case (r_op)
                        OP_V: begin
                            n_v = (r_div == '0) ? '0 : ((|n_dq[47:32]) ? '1 : n_dq[31:0]);
                            n_op = OP_I;
                        end
                        OP_I: begin
                            n_i = (r_div == '0) ? '0 : ((|n_dq[47:32]) ? '1 : n_dq[31:0]);
                            n_op = OP_P;
                        end
                        OP_P: begin
                            n_p = (r_div == '0) ? '0 : ((|n_dq[47:32]) ? '1 : n_dq[31:0]);
                            n_op = OP_S;
                        end
                        default: begin
                            n_pf = (r_div == '0) ? '0
                                 : ((|n_dq[47:PF_W]) ? '1 : n_dq[PF_W-1:0]);
                        end
                    endcase
                    if (r_op == OP_PF) begin
                        n_state = ST_FIN;
                    end else begin
                        n_state = ST_MUL;
                        n_acc = '0;
                    end
                end
            end
            ST_FIN: begin
                if (!r_m_valid || m_axis_tready) begin
                    n_m_valid = 1'b1;
                    n_m_data = {6'd0, r_pulse, r_pf, r_s, r_p, r_i, r_v};
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
        // operand load for a multiply pass
        if (n_state == ST_MUL && (r_state != ST_MUL)) begin
            n_acc = '0;
            n_cnt = '0;
            if (n_op == OP_S) begin
                n_ma = n_v;
                n_mb = n_i;
            end else begin
                n_ma = {8'd0, sel_param};
                n_mb = {12'd0, sel_coef};
                n_div = {8'd0, sel_count};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_op <= OP_V;
            r_pos <= '0;
            r_cnt <= '0;
            r_m_valid <= 1'b0;
            r_vcoef <= VCOEF_RESET;
            r_icoef <= ICOEF_RESET;
            r_pcoef <= PCOEF_RESET;
        end else begin
            r_state <= n_state;
            r_op <= n_op;
            r_pos <= n_pos;
            r_cnt <= n_cnt;
            r_m_valid <= n_m_valid;
            if (i_cfg_we) begin
                unique case (t_reg'(i_cfg_addr))
                    REG_VCOEF: r_vcoef <= i_cfg_wdata;
                    REG_ICOEF: r_icoef <= i_cfg_wdata;
                    REG_PCOEF: r_pcoef <= i_cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    // frame capture and datapath
    always_ff @(posedge i_clk) begin
        if (rx_beat && r_pos >= POS_W'(2) && s_axis_tdata != SYNC_BYTE) begin
            if (r_pos <= POS_W'(19)) begin
                r_frame <= {r_frame[135:0], s_axis_tdata};
            end
            if (r_pos == POS_W'(21) || r_pos == POS_W'(22)) begin
                r_pulse <= {r_pulse[7:0], s_axis_tdata};
            end
        end
        r_ma <= n_ma;
        r_mb <= n_mb;
        r_acc <= n_acc;
        r_div <= n_div;
        r_rem <= n_rem;
        r_dq <= n_dq;
        r_v <= n_v;
        r_i <= n_i;
        r_p <= n_p;
        r_s <= n_s;
        r_pf <= n_pf;
        r_m_data <= n_m_data;
    end

    `EMFD_ASSERT(a_pos_range, r_pos < POS_W'(FRAME_LENGTH), "frame position out of range")
    `EMFD_ASSERT(a_frame_starts, frame_done |=> r_state == ST_MUL, "finished frame not computed")
    `EMFD_ASSERT(a_out_from_fin, $rose(r_m_valid) |-> $past(r_state == ST_FIN), "stray result")
    `EMFD_ASSERT_ALWAYS(a_reset_idle, !i_rst_n |=> r_state == ST_IDLE && !r_m_valid, "reset")
endmodule
